@@ sv/plc_pkg.sv @@
`timescale 1ns / 1ps
// Package for the partitioned LRU tag cache: fixed field widths, result
// status codes, command codes and the scan status struct. No dependencies.
package plc_pkg;

    localparam int ATTR_W   = 25;
    localparam int STAMP_W  = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 6;
    localparam int RSV_W    = 6;
    localparam int STYLE_W  = 8;
    localparam int SIZE_W   = 16;

    localparam logic [RSV_W-1:0] RESERVE_RESET = 6'd10;

    localparam logic CMD_LOOKUP  = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_HIT     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FILL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REPLACE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FAIL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RELEASE = 3'd4;

    // Status of the slot scan as seen by the controller.
    typedef struct packed {
        logic hit_now;
        logic rel_now;
        logic owner_has;
        logic take_free;
    } t_scan_sts;

endpackage

@@ sv/plc_mem.sv @@
`timescale 1ns / 1ps
// Slot entry memory: one write port and one registered read port.
// Standalone; used by partitioned_lru_tag_cache.
module plc_mem #(
    parameter int DEPTH = 40,
    parameter int WIDTH = 129
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/plc_scan.sv @@
`timescale 1ns / 1ps
// Slot scan unit: compares one returned entry per cycle with the request and
// accumulates free slots, the owner's oldest slot and the release count. Uses plc_pkg.
module plc_scan #(
    parameter int SLOTS      = 40,
    parameter int OWNER_BITS = 8,
    parameter int TAG_BITS   = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_ent_vld,
    input  logic [$clog2(SLOTS)-1:0]    i_ent_idx,
    input  logic                        i_slot_valid,
    input  logic                        i_release,
    input  logic [OWNER_BITS-1:0]       i_ent_owner,
    input  logic [TAG_BITS-1:0]         i_ent_name,
    input  logic [TAG_BITS-1:0]         i_ent_resolved,
    input  logic [plc_pkg::ATTR_W-1:0]  i_ent_attrs,
    input  logic [plc_pkg::STAMP_W-1:0] i_ent_stamp,
    input  logic [OWNER_BITS-1:0]       i_req_owner,
    input  logic [TAG_BITS-1:0]         i_req_name,
    input  logic [plc_pkg::ATTR_W-1:0]  i_req_attrs,
    input  logic [plc_pkg::STAMP_W-1:0] i_clock,
    input  logic [plc_pkg::RSV_W-1:0]   i_reserve,
    output plc_pkg::t_scan_sts          o_sts,
    output logic [$clog2(SLOTS)-1:0]    o_free_idx,
    output logic [$clog2(SLOTS)-1:0]    o_lru_idx,
    output logic [$clog2(SLOTS+1)-1:0]  o_freed
);

    localparam int IDXW = $clog2(SLOTS);
    localparam int CNTW = $clog2(SLOTS + 1);
    localparam int CMPW = (CNTW > plc_pkg::RSV_W) ? CNTW : plc_pkg::RSV_W;

    logic                        r_owner_has;
    logic                        r_have_free;
    logic [IDXW-1:0]             r_free_idx;
    logic [IDXW-1:0]             r_lru_idx;
    logic [plc_pkg::STAMP_W-1:0] r_lru_age;
    logic [CNTW-1:0]             r_free_cnt;
    logic [CNTW-1:0]             r_freed;

    logic                        owner_eq;
    logic                        mine;
    logic                        is_free;
    logic [plc_pkg::STAMP_W-1:0] age;
    logic                        hit_now;
    logic                        rel_now;

    assign owner_eq = (i_ent_owner == i_req_owner);
    assign mine     = i_ent_vld && i_slot_valid && owner_eq;
    assign is_free  = i_ent_vld && !i_release && !i_slot_valid;
    // Age wraps with the access clock, as the stamps do.
    assign age      = i_clock - i_ent_stamp;
    assign hit_now  = mine && !i_release && (i_ent_attrs == i_req_attrs) &&
                      ((i_ent_name == i_req_name) || (i_ent_resolved == i_req_name));
    assign rel_now  = mine && i_release;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_owner_has <= 1'b0;
            r_have_free <= 1'b0;
            r_free_idx  <= '0;
            r_lru_idx   <= '0;
            r_lru_age   <= '0;
            r_free_cnt  <= '0;
            r_freed     <= '0;
        end else begin
            if (mine && !i_release && (!r_owner_has || age > r_lru_age)) begin
                r_owner_has <= 1'b1;
                r_lru_idx   <= i_ent_idx;
                r_lru_age   <= age;
            end
            if (is_free) begin
                if (!r_have_free) begin
                    r_have_free <= 1'b1;
                    r_free_idx  <= i_ent_idx;
                end
                r_free_cnt <= r_free_cnt + 1'b1;
            end
            if (rel_now) begin
                r_freed <= r_freed + 1'b1;
            end
        end
    end

    always_comb begin
        o_sts.hit_now   = hit_now;
        o_sts.rel_now   = rel_now;
        o_sts.owner_has = r_owner_has;
        o_sts.take_free = r_have_free &&
                          (!r_owner_has || (CMPW'(r_free_cnt) > CMPW'(i_reserve)));
    end

    assign o_free_idx = r_free_idx;
    assign o_lru_idx  = r_lru_idx;
    assign o_freed    = r_freed;

endmodule

@@ sv/partitioned_lru_tag_cache.sv @@
`timescale 1ns / 1ps
// Partitioned LRU tag cache, top level. Holds the controller, the valid bits
// and the output register; uses plc_pkg, plc_mem and plc_scan.
//
// A fully associative table of SLOTS entries shared by owners. Each accepted
// transaction (lookup/fill or release) is handled alone by a sequential scan
// that reads one entry per cycle from the entry memory (one read port, one
// write port). A full scan reads every slot in order and registers each read;
// once the scan closes, the finish state (held while a stalled result waits)
// writes back, loads the result and returns to idle, where the next
// transaction is taken. A lookup that hits slot k stops there. The entry
// memory needs no clearing pass: valid bits in flip-flops, cleared by reset,
// gate every compare. A new transaction is taken while a finished result
// still waits downstream; it can only deliver once that result has gone.
// The user must write reserve_free_slots through the configuration port
// (always ready) only while the block is idle; the block does not enforce it.
module partitioned_lru_tag_cache #(
    parameter int SLOTS      = 40,
    parameter int OWNER_BITS = 8,
    parameter int TAG_BITS   = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_cmd,
    input  logic [OWNER_BITS-1:0]         i_owner_id,
    input  logic [TAG_BITS-1:0]           i_name_tag,
    input  logic [TAG_BITS-1:0]           i_resolved_tag,
    input  logic                          i_smooth_flag,
    input  logic [plc_pkg::STYLE_W-1:0]   i_style_bits,
    input  logic [plc_pkg::SIZE_W-1:0]    i_size_code,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [plc_pkg::STATUS_W-1:0]  o_status,
    output logic [plc_pkg::SLOT_W-1:0]    o_slot_index,
    output logic [plc_pkg::COUNT_W-1:0]   o_freed_count,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [plc_pkg::RSV_W-1:0]     i_cfg_data
);

    localparam int IDXW    = $clog2(SLOTS);
    localparam int CNTW    = $clog2(SLOTS + 1);
    localparam int STW     = plc_pkg::STAMP_W;
    localparam int ENTRY_W = OWNER_BITS + 2 * TAG_BITS + plc_pkg::ATTR_W + STW;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]                  r_state;
    logic [plc_pkg::RSV_W-1:0]   r_reserve;
    logic [STW-1:0]              r_clock;
    logic                        r_release;
    logic [OWNER_BITS-1:0]       r_owner;
    logic [TAG_BITS-1:0]         r_name;
    logic [TAG_BITS-1:0]         r_resolved;
    logic [plc_pkg::ATTR_W-1:0]  r_attrs;
    logic [CNTW-1:0]             r_issue_cnt;
    logic                        r_data_vld;
    logic [IDXW-1:0]             r_data_idx;
    logic                        r_hit;
    logic [IDXW-1:0]             r_target;
    logic [SLOTS-1:0]            r_valid;
    logic                        r_out_valid;
    logic [plc_pkg::STATUS_W-1:0] r_status;
    logic [plc_pkg::SLOT_W-1:0]  r_slot_index;
    logic [plc_pkg::COUNT_W-1:0] r_freed_count;

    logic                        in_accept;
    logic                        issue_more;
    logic                        rd_en;
    logic [IDXW-1:0]             rd_addr;
    logic [ENTRY_W-1:0]          rd_data;
    logic                        scan_vld;
    logic                        scan_done;
    logic                        fin_go;
    logic                        mem_we;
    logic [ENTRY_W-1:0]          mem_wdata;
    logic [plc_pkg::STATUS_W-1:0] n_status;
    logic [IDXW-1:0]             n_target;
    logic                        n_set_valid;
    plc_pkg::t_scan_sts          sts;
    logic [IDXW-1:0]             free_idx;
    logic [IDXW-1:0]             lru_idx;
    logic [CNTW-1:0]             freed;

    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign scan_vld   = (r_state == S_SCAN) && r_data_vld;
    assign issue_more = (r_issue_cnt < CNTW'(SLOTS));
    // Reads stop on a hit so that the read register keeps the hit entry.
    assign rd_en      = (r_state == S_SCAN) && issue_more && !sts.hit_now;
    assign rd_addr    = r_issue_cnt[IDXW-1:0];
    assign scan_done  = !issue_more && !r_data_vld;
    assign fin_go     = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);

    plc_mem #(
        .DEPTH (SLOTS),
        .WIDTH (ENTRY_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (n_target),
        .i_wdata (mem_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    plc_scan #(
        .SLOTS      (SLOTS),
        .OWNER_BITS (OWNER_BITS),
        .TAG_BITS   (TAG_BITS)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (in_accept),
        .i_ent_vld      (scan_vld),
        .i_ent_idx      (r_data_idx),
        .i_slot_valid   (r_valid[r_data_idx]),
        .i_release      (r_release),
        .i_ent_owner    (rd_data[ENTRY_W-1 -: OWNER_BITS]),
        .i_ent_name     (rd_data[STW + plc_pkg::ATTR_W + TAG_BITS +: TAG_BITS]),
        .i_ent_resolved (rd_data[STW + plc_pkg::ATTR_W +: TAG_BITS]),
        .i_ent_attrs    (rd_data[STW +: plc_pkg::ATTR_W]),
        .i_ent_stamp    (rd_data[STW-1:0]),
        .i_req_owner    (r_owner),
        .i_req_name     (r_name),
        .i_req_attrs    (r_attrs),
        .i_clock        (r_clock),
        .i_reserve      (r_reserve),
        .o_sts          (sts),
        .o_free_idx     (free_idx),
        .o_lru_idx      (lru_idx),
        .o_freed        (freed)
    );

    // Final decision once the scan has closed.
    always_comb begin
        n_status    = plc_pkg::ST_FAIL;
        n_target    = '0;
        n_set_valid = 1'b0;
        mem_wdata   = {r_owner, r_name, r_resolved, r_attrs, r_clock};
        if (r_release) begin
            n_status = plc_pkg::ST_RELEASE;
        end else if (r_hit) begin
            n_status    = plc_pkg::ST_HIT;
            n_target    = r_target;
            n_set_valid = 1'b1;
            // A hit refreshes only the stamp.
            mem_wdata   = {rd_data[ENTRY_W-1:STW], r_clock};
        end else if (sts.take_free) begin
            n_status    = plc_pkg::ST_FILL;
            n_target    = free_idx;
            n_set_valid = 1'b1;
        end else if (sts.owner_has) begin
            n_status    = plc_pkg::ST_REPLACE;
            n_target    = lru_idx;
            n_set_valid = 1'b1;
        end
    end

    // Writes happen only in the finish cycle and reads only while scanning,
    // so no access to an entry can overlap its write-back.
    assign mem_we = fin_go && n_set_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_reserve   <= plc_pkg::RESERVE_RESET;
            r_clock     <= '0;
            r_issue_cnt <= '0;
            r_data_vld  <= 1'b0;
            r_hit       <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_reserve <= i_cfg_data;
            end
            r_data_vld <= rd_en;
            if (rd_en) begin
                r_issue_cnt <= r_issue_cnt + 1'b1;
            end
            if (sts.rel_now) begin
                r_valid[r_data_idx] <= 1'b0;
            end
            if (mem_we) begin
                r_valid[n_target] <= 1'b1;
            end

            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state     <= S_SCAN;
                        r_issue_cnt <= '0;
                        r_hit       <= 1'b0;
                        if (i_cmd == plc_pkg::CMD_LOOKUP) begin
                            r_clock <= r_clock + 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    if (sts.hit_now) begin
                        r_hit   <= 1'b1;
                        r_state <= S_FINISH;
                    end else if (scan_done) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (fin_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_release  <= (i_cmd == plc_pkg::CMD_RELEASE);
            r_owner    <= i_owner_id;
            r_name     <= i_name_tag;
            r_resolved <= i_resolved_tag;
            r_attrs    <= {i_smooth_flag, i_style_bits, i_size_code};
        end
        if (rd_en) begin
            r_data_idx <= rd_addr;
        end
        if (sts.hit_now) begin
            r_target <= r_data_idx;
        end
        if (fin_go) begin
            r_status      <= n_status;
            r_slot_index  <= plc_pkg::SLOT_W'(n_target);
            r_freed_count <= r_release ? plc_pkg::COUNT_W'(freed) : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_slot_index  = r_slot_index;
    assign o_freed_count = r_freed_count;

endmodule

@@ sv/plc_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for partitioned_lru_tag_cache and its bind statement.
// Uses plc_pkg for the status codes.
module plc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [plc_pkg::STATUS_W-1:0] o_status,
    input logic [plc_pkg::SLOT_W-1:0]   o_slot_index,
    input logic [plc_pkg::COUNT_W-1:0]  o_freed_count
);

    // The block works on one transaction at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an accepted transaction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status) &&
        $stable(o_slot_index) && $stable(o_freed_count)))
        else $error("stalled result changed");

    a_release_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == plc_pkg::ST_RELEASE) |-> (o_slot_index == '0))
        else $error("release result carries a slot index");

    a_lookup_freed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != plc_pkg::ST_RELEASE) |-> (o_freed_count == '0))
        else $error("lookup result carries a freed count");

    a_fail_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == plc_pkg::ST_FAIL) |-> (o_slot_index == '0))
        else $error("failed lookup carries a slot index");

endmodule

bind partitioned_lru_tag_cache plc_checker u_plc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_slot_index  (o_slot_index),
    .o_freed_count (o_freed_count)
);
